// ===== rtl/core/bresenham_line_pixel_generator_defines.svh =====
// Assertion helpers shared by the line generator RTL.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BLG_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same, on the default clock and reset names of this block.
`define BLG_ASSERT(lbl, prop, msg) `BLG_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/blg_pkg.sv =====
package blg_pkg;

  // Default coordinate width and fixed colour width
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOUR_BITS    = 16;

  // Request codes carried on the input tuser
  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_RESUME = 2'd1,
    REQ_STEP   = 2'd2
  } req_e;

  // Direction flags of a loaded line
  typedef struct packed {
    logic x_is_major;
    logic minor_dec;
  } line_dir_t;

endpackage

// ===== rtl/core/blg_setup.sv =====
// Line setup: orders the endpoints along the major axis and derives the
// deltas, the initial decision value and the direction flags.
module blg_setup #(
  parameter int unsigned CW = blg_pkg::COORD_BITS_DEF
) (
  input  logic signed [CW-1:0] x0_i,
  input  logic signed [CW-1:0] y0_i,
  input  logic signed [CW-1:0] x1_i,
  input  logic signed [CW-1:0] y1_i,
  output logic signed [CW-1:0] pos_x_o,
  output logic signed [CW-1:0] pos_y_o,
  output logic signed [CW-1:0] major_stop_o,
  output logic        [CW:0]   major_delta_o,
  output logic        [CW:0]   minor_delta_o,
  output logic signed [CW+2:0] error_o,
  output blg_pkg::line_dir_t   dir_o
);

  logic signed [CW:0] dx, dy, d_min;
  logic        [CW:0] adx, ady, abs_maj, abs_min;
  logic               x_major, swap;

  // Signed differences and their magnitudes
  assign dx  = {x1_i[CW-1], x1_i} - {x0_i[CW-1], x0_i};
  assign dy  = {y1_i[CW-1], y1_i} - {y0_i[CW-1], y0_i};
  assign adx = dx[CW] ? (CW+1)'(-dx) : dx;
  assign ady = dy[CW] ? (CW+1)'(-dy) : dy;

  // Axis choice; swap when the major axis runs downward
  assign x_major = ady < adx;
  assign swap    = x_major ? dx[CW] : dy[CW];
  assign d_min   = x_major ? dy : dx;
  assign abs_maj = x_major ? adx : ady;
  assign abs_min = x_major ? ady : adx;

  // Swapping the endpoints flips the minor direction
  assign dir_o.x_is_major = x_major;
  assign dir_o.minor_dec  = swap ? (!d_min[CW] && (|d_min)) : d_min[CW];

  assign pos_x_o      = swap ? x1_i : x0_i;
  assign pos_y_o      = swap ? y1_i : y0_i;
  assign major_stop_o = x_major ? (swap ? x0_i : x1_i) : (swap ? y0_i : y1_i);

  assign major_delta_o = abs_maj;
  assign minor_delta_o = abs_min;
  assign error_o       = $signed({1'b0, abs_min, 1'b0} - {2'b00, abs_maj});

endmodule

// ===== rtl/core/bresenham_line_pixel_generator.sv =====
// Bresenham line pixel generator, pull style.
// Input stream: tuser carries the request (start, start from the saved end,
// step); tdata carries both endpoints and the colour. Every accepted word
// produces exactly one output word. Output tuser flags a real pixel, tdata
// carries its coordinates and colour, and tlast marks the final pixel of a
// line. Start requests and steps while idle give a word with tuser low and
// zero data.
// Pipeline: an accepted word is held in the input register, the setup
// or step logic runs on it and the result is shown in the output
// register. Throughput is one word per clock unless the receiver
// stalls, limited by the single add-and-compare step on the line state.
// If the receiver stalls, the pending result stays in the output register
// and one more input word is taken into the input register; tready drops
// only when both are occupied.
// Reset (rst_ni low, asynchronous) clears both registers' valid flags, the
// line state (idle) and the saved end point to zero.
`include "bresenham_line_pixel_generator_defines.svh"

module bresenham_line_pixel_generator #(
  parameter int unsigned COORD_BITS = blg_pkg::COORD_BITS_DEF,
  localparam int unsigned CW    = COORD_BITS,
  localparam int unsigned CB    = blg_pkg::COLOUR_BITS,
  localparam int unsigned IN_W  = ((4 * COORD_BITS + 16 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + 16 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // x_start, y_start, x_end, y_end, colour (from bit 0 up), zero padded
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [1:0]       s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // pixel_x, pixel_y, pixel_colour (from bit 0 up), zero padded
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // pixel_valid
  output logic             m_axis_tuser_o,
  // last_pixel
  output logic             m_axis_tlast_o
);

  // Input register
  logic                 in_valid_q;
  blg_pkg::req_e        req_q;
  logic signed [CW-1:0] xs_q, ys_q, xe_q, ye_q;
  logic [CB-1:0]        col_q;

  // Line state
  logic signed [CW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [CW-1:0] major_stop_q, major_stop_d;
  logic signed [CW+2:0] error_q, error_d;
  logic [CW:0]          maj_d_q, maj_d_d, min_d_q, min_d_d;
  blg_pkg::line_dir_t   dir_q, dir_d;
  logic                 active_q, active_d;
  logic [CB-1:0]        line_col_q, line_col_d;
  logic signed [CW-1:0] saved_x_q, saved_x_d, saved_y_q, saved_y_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_pix_q, out_pix_d, out_last_q, out_last_d;
  logic signed [CW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CB-1:0]        out_col_q, out_col_d;

  logic adv, in_acc;

  // Handshake: the compute stage advances when the output slot frees up
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input word capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= blg_pkg::req_e'(s_axis_tuser_i);
      xs_q  <= s_axis_tdata_i[CW-1:0];
      ys_q  <= s_axis_tdata_i[2*CW-1:CW];
      xe_q  <= s_axis_tdata_i[3*CW-1:2*CW];
      ye_q  <= s_axis_tdata_i[4*CW-1:3*CW];
      col_q <= s_axis_tdata_i[4*CW +: CB];
    end
  end

  // Line setup for both start requests
  logic signed [CW-1:0] su_x0, su_y0, su_px, su_py, su_stop;
  logic [CW:0]          su_maj, su_min;
  logic signed [CW+2:0] su_err;
  blg_pkg::line_dir_t   su_dir;

  assign su_x0 = (req_q == blg_pkg::REQ_RESUME) ? saved_x_q : xs_q;
  assign su_y0 = (req_q == blg_pkg::REQ_RESUME) ? saved_y_q : ys_q;

  blg_setup #(
    .CW (CW)
  ) u_setup (
    .x0_i          (su_x0),
    .y0_i          (su_y0),
    .x1_i          (xe_q),
    .y1_i          (ye_q),
    .pos_x_o       (su_px),
    .pos_y_o       (su_py),
    .major_stop_o  (su_stop),
    .major_delta_o (su_maj),
    .minor_delta_o (su_min),
    .error_o       (su_err),
    .dir_o         (su_dir)
  );

  // Step datapath
  logic signed [CW-1:0] cur_major, cur_minor, major_nx, minor_nx;
  logic signed [CW+2:0] min2, step_gain;
  logic                 last, err_pos;

  assign cur_major = dir_q.x_is_major ? pos_x_q : pos_y_q;
  assign cur_minor = dir_q.x_is_major ? pos_y_q : pos_x_q;
  assign last      = cur_major >= major_stop_q;
  assign err_pos   = error_q > 0;
  assign major_nx  = cur_major + CW'(1);
  assign minor_nx  = dir_q.minor_dec ? cur_minor - CW'(1) : cur_minor + CW'(1);
  assign min2      = $signed({1'b0, min_d_q, 1'b0});
  assign step_gain = err_pos ? $signed({1'b0, min_d_q, 1'b0} - {1'b0, maj_d_q, 1'b0})
                             : min2;

  // Next state and result
  always_comb begin
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    major_stop_d = major_stop_q;
    error_d      = error_q;
    maj_d_d      = maj_d_q;
    min_d_d      = min_d_q;
    dir_d        = dir_q;
    active_d     = active_q;
    line_col_d   = line_col_q;
    saved_x_d    = saved_x_q;
    saved_y_d    = saved_y_q;
    out_pix_d    = 1'b0;
    out_last_d   = 1'b0;
    out_x_d      = '0;
    out_y_d      = '0;
    out_col_d    = '0;
    if (adv) begin
      unique case (req_q)
        blg_pkg::REQ_START, blg_pkg::REQ_RESUME: begin
          pos_x_d      = su_px;
          pos_y_d      = su_py;
          major_stop_d = su_stop;
          error_d      = su_err;
          maj_d_d      = su_maj;
          min_d_d      = su_min;
          dir_d        = su_dir;
          active_d     = 1'b1;
          line_col_d   = col_q;
          saved_x_d    = xe_q;
          saved_y_d    = ye_q;
        end
        blg_pkg::REQ_STEP: begin
          if (active_q) begin
            out_pix_d  = 1'b1;
            out_last_d = last;
            out_x_d    = pos_x_q;
            out_y_d    = pos_y_q;
            out_col_d  = line_col_q;
            if (last) begin
              active_d = 1'b0;
            end else begin
              error_d = error_q + step_gain;
              if (dir_q.x_is_major) begin
                pos_x_d = major_nx;
                pos_y_d = err_pos ? minor_nx : pos_y_q;
              end else begin
                pos_y_d = major_nx;
                pos_x_d = err_pos ? minor_nx : pos_x_q;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      major_stop_q <= '0;
      error_q      <= '0;
      maj_d_q      <= '0;
      min_d_q      <= '0;
      dir_q        <= '0;
      active_q     <= 1'b0;
      line_col_q   <= '0;
      saved_x_q    <= '0;
      saved_y_q    <= '0;
    end else begin
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      major_stop_q <= major_stop_d;
      error_q      <= error_d;
      maj_d_q      <= maj_d_d;
      min_d_q      <= min_d_d;
      dir_q        <= dir_d;
      active_q     <= active_d;
      line_col_q   <= line_col_d;
      saved_x_q    <= saved_x_d;
      saved_y_q    <= saved_y_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q  <= out_pix_d;
      out_last_q <= out_last_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_col_q  <= out_col_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_pix_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[2*CW+CB-1:0] = {out_col_q, out_y_q, out_x_q};
  end

  // Checks
  logic step_last;
  assign step_last = adv && (req_q == blg_pkg::REQ_STEP) && active_q && last;

  `BLG_ASSERT(a_stall_holds_input, !s_axis_tready_o |-> in_valid_q, "tready low, input empty")
  `BLG_ASSERT(a_walk_bounded, active_q |-> (cur_major <= major_stop_q), "walk passed line end")
  `BLG_ASSERT(a_minor_le_major, active_q |-> (min_d_q <= maj_d_q), "minor delta above major")
  `BLG_ASSERT(a_last_ends_line, step_last |=> !active_q, "line active after last pixel")

endmodule
